// ===== design/vas_pkg.sv =====
// ----------------------------------------------------------------------------
// vas_pkg
// shared types, codes and helpers of the voice allocator
// ----------------------------------------------------------------------------
package vas_pkg;

    localparam int VOICES_DEF = 16;
    // group members freed by a steal that still get their own result item
    localparam int MAX_REPORT = 15;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        EV_ALLOC   = 2'd0,
        EV_STOLEN  = 2'd1,
        EV_RELEASE = 2'd2,
        EV_CLEAR   = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ST_FREE      = 2'd0,
        ST_HELD      = 2'd1,
        ST_RELEASING = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMP_STAMP_LT = 2'd0,
        CMP_GROUP_EQ = 2'd1,
        CMP_KEY_EQ   = 2'd2
    } cmp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASCAN,
        S_ADECIDE,
        S_AGRP,
        S_GSCAN,
        S_AVICT,
        S_AWRITE,
        S_RSCAN,
        S_REMIT,
        S_CLEAR
    } state_t;

    // one voice record in the slot memory
    typedef struct packed {
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [15:0] group;
        logic [31:0] stamp;
    } rec_t;

    // input item as seen by the sequencer
    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [15:0] group_id;
    } cmd_t;

    // result item handed from the sequencer to the output register
    typedef struct packed {
        logic        valid;
        event_t      kind;
        logic [3:0]  slot;
        logic [4:0]  released_count;
        logic [4:0]  active_voices;
        logic        last;
    } emit_t;

    // bits needed to index a pool of n slots
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== design/vas_rec_mem.sv =====
// ----------------------------------------------------------------------------
// vas_rec_mem
// voice record memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module vas_rec_mem
    import vas_pkg::*;
#(
    parameter int DEPTH = VOICES_DEF
)
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [idx_width(DEPTH)-1:0]   waddr,
    input  rec_t                          wdata,
    input  logic                          re,
    input  logic [idx_width(DEPTH)-1:0]   raddr,
    output rec_t                          rdata
);

    rec_t mem_reg [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/vas_cmp.sv =====
// ----------------------------------------------------------------------------
// vas_cmp
// shared compare unit: stamp order, group match or channel and note match
// ----------------------------------------------------------------------------
module vas_cmp
    import vas_pkg::*;
(
    input  cmp_op_t     op,
    input  rec_t        rec,
    input  logic [31:0] best_stamp,
    input  logic [15:0] group,
    input  logic [3:0]  channel,
    input  logic [6:0]  note,
    output logic        hit
);

    always_comb
    begin
        case (op)
            CMP_STAMP_LT: hit = (rec.stamp < best_stamp);
            CMP_GROUP_EQ: hit = (rec.group == group);
            CMP_KEY_EQ:   hit = (rec.channel == channel) && (rec.note == note);
            default:      hit = 1'b0;
        endcase
    end

endmodule

// ===== design/vas_ctrl.sv =====
// ----------------------------------------------------------------------------
// vas_ctrl
// sequencer: slot status, scans over the record memory, result generation
// ----------------------------------------------------------------------------
module vas_ctrl
    import vas_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  cmd_t  cmd_in,
    input  logic  out_free,
    output logic  idle,
    output emit_t emit
);

    localparam int IDXW = idx_width(VOICES);
    localparam int CW   = $clog2(VOICES + 1);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    status_t           status_reg [VOICES];
    status_t           status_next [VOICES];
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              eval_vld_reg, eval_vld_next;
    logic [IDXW-1:0]   eval_idx_reg, eval_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDXW-1:0]   free_idx_reg, free_idx_next;
    logic              rel_found_reg, rel_found_next;
    logic [IDXW-1:0]   rel_idx_reg, rel_idx_next;
    logic [31:0]       rel_best_reg, rel_best_next;
    logic              held_found_reg, held_found_next;
    logic [IDXW-1:0]   held_idx_reg, held_idx_next;
    logic [31:0]       held_best_reg, held_best_next;
    logic [IDXW-1:0]   vict_reg, vict_next;
    logic [15:0]       vg_reg, vg_next;
    logic [3:0]        emit_cnt_reg, emit_cnt_next;
    logic [CW-1:0]     rel_cnt_reg, rel_cnt_next;
    logic [CW-1:0]     active_reg, active_next;
    logic [31:0]       age_reg, age_next;

    // memory and compare unit hookup
    logic              mem_we, mem_re;
    logic [IDXW-1:0]   mem_raddr;
    rec_t              mem_wdata, mem_rdata;
    cmp_op_t           cmp_op;
    logic [31:0]       cmp_best;
    logic              cmp_hit;

    // helpers
    status_t           cur_status;
    logic              scan_issue, scan_done, advance;
    logic              group_hit, report;
    logic [IDXW-1:0]   victim_c;
    logic [31:0]       age_inc;
    logic [CW-1:0]     act_dec, act_inc;
    logic [CW+4:0]     act_w, act_dec_w, act_inc_w, rel_w;
    logic [IDXW+3:0]   eidx_w, vict_w;

    vas_rec_mem #(
        .DEPTH (VOICES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (vict_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    vas_cmp u_cmp (
        .op         (cmp_op),
        .rec        (mem_rdata),
        .best_stamp (cmp_best),
        .group      (vg_reg),
        .channel    (cmd_reg.channel),
        .note       (cmd_reg.note),
        .hit        (cmp_hit)
    );

    assign cur_status = status_reg[eval_idx_reg];
    assign scan_issue = (cnt_reg < CW'(VOICES));
    assign scan_done  = (cnt_reg == CW'(VOICES)) && !eval_vld_reg;
    assign age_inc    = (age_reg == '1) ? age_reg : age_reg + 32'd1;
    assign act_dec    = active_reg - CW'(1);
    assign act_inc    = active_reg + CW'(1);
    assign act_w      = {5'b0, active_reg};
    assign act_dec_w  = {5'b0, act_dec};
    assign act_inc_w  = {5'b0, act_inc};
    assign rel_w      = {5'b0, rel_cnt_reg};
    assign eidx_w     = {4'b0, eval_idx_reg};
    assign vict_w     = {4'b0, vict_reg};
    assign idle       = (state_reg == S_IDLE);

    assign cmp_best = (cur_status == ST_RELEASING) ? rel_best_reg : held_best_reg;

    always_comb
    begin
        case (state_reg)
            S_ASCAN: cmp_op = CMP_STAMP_LT;
            S_GSCAN: cmp_op = CMP_GROUP_EQ;
            default: cmp_op = CMP_KEY_EQ;
        endcase
    end

    // victim priority: lowest free, then oldest releasing, then oldest held
    always_comb
    begin
        if (free_found_reg)
            victim_c = free_idx_reg;
        else if (rel_found_reg)
            victim_c = rel_idx_reg;
        else if (held_found_reg)
            victim_c = held_idx_reg;
        else
            victim_c = '0;
    end

    assign group_hit = (state_reg == S_GSCAN) && eval_vld_reg && cmp_hit
                       && (cur_status != ST_FREE) && (eval_idx_reg != vict_reg);
    assign report    = group_hit && (emit_cnt_reg < 4'(MAX_REPORT));
    assign advance   = !(report && !out_free);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd_in.opcode)
                        OP_ALLOC:   state_next = S_ASCAN;
                        OP_RELEASE: state_next = S_RSCAN;
                        OP_CLEAR:   state_next = S_CLEAR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ASCAN:   if (scan_done) state_next = S_ADECIDE;
            S_ADECIDE: state_next = S_AGRP;
            S_AGRP:
            begin
                if (status_reg[vict_reg] == ST_FREE)
                    state_next = S_AWRITE;
                else if (mem_rdata.group == 16'd0)
                    state_next = S_AVICT;
                else
                    state_next = S_GSCAN;
            end
            S_GSCAN:   if (scan_done) state_next = S_AVICT;
            S_AVICT:   if (out_free) state_next = S_AWRITE;
            S_AWRITE:  if (out_free) state_next = S_IDLE;
            S_RSCAN:   if (scan_done) state_next = S_REMIT;
            S_REMIT:   if (out_free) state_next = S_IDLE;
            S_CLEAR:   if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        status_next     = status_reg;
        cnt_next        = cnt_reg;
        eval_vld_next   = eval_vld_reg;
        eval_idx_next   = eval_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        rel_found_next  = rel_found_reg;
        rel_idx_next    = rel_idx_reg;
        rel_best_next   = rel_best_reg;
        held_found_next = held_found_reg;
        held_idx_next   = held_idx_reg;
        held_best_next  = held_best_reg;
        vict_next       = vict_reg;
        vg_next         = vg_reg;
        emit_cnt_next   = emit_cnt_reg;
        rel_cnt_next    = rel_cnt_reg;
        active_next     = active_reg;
        age_next        = age_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = cnt_reg[IDXW-1:0];
        mem_wdata       = '{channel:  cmd_reg.channel,
                            note:     cmd_reg.note,
                            velocity: cmd_reg.velocity,
                            group:    cmd_reg.group_id,
                            stamp:    age_inc};
        emit            = '{valid: 1'b0, kind: EV_ALLOC, slot: 4'd0,
                            released_count: 5'd0, active_voices: act_w[4:0],
                            last: 1'b0};

        // common scan pipeline: issue a read, then evaluate the registered read data
        if ((state_reg == S_ASCAN || state_reg == S_GSCAN || state_reg == S_RSCAN)
            && advance)
        begin
            if (scan_issue)
            begin
                mem_re        = 1'b1;
                cnt_next      = cnt_reg + CW'(1);
                eval_vld_next = 1'b1;
                eval_idx_next = cnt_reg[IDXW-1:0];
            end
            else
            begin
                eval_vld_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd_in;
                    cnt_next        = '0;
                    eval_vld_next   = 1'b0;
                    free_found_next = 1'b0;
                    rel_found_next  = 1'b0;
                    held_found_next = 1'b0;
                    rel_cnt_next    = '0;
                end
            end
            S_ASCAN:
            begin
                if (eval_vld_reg)
                begin
                    case (cur_status)
                        ST_FREE:
                        begin
                            if (!free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = eval_idx_reg;
                            end
                        end
                        ST_RELEASING:
                        begin
                            if (!rel_found_reg || cmp_hit)
                            begin
                                rel_found_next = 1'b1;
                                rel_idx_next   = eval_idx_reg;
                                rel_best_next  = mem_rdata.stamp;
                            end
                        end
                        ST_HELD:
                        begin
                            if (!held_found_reg || cmp_hit)
                            begin
                                held_found_next = 1'b1;
                                held_idx_next   = eval_idx_reg;
                                held_best_next  = mem_rdata.stamp;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADECIDE:
            begin
                // fetch the victim record for its group
                vict_next = victim_c;
                mem_re    = 1'b1;
                mem_raddr = victim_c;
            end
            S_AGRP:
            begin
                vg_next       = mem_rdata.group;
                cnt_next      = '0;
                eval_vld_next = 1'b0;
                emit_cnt_next = '0;
            end
            S_GSCAN:
            begin
                if (group_hit && advance)
                begin
                    status_next[eval_idx_reg] = ST_FREE;
                    active_next               = act_dec;
                    if (report)
                    begin
                        emit_cnt_next = emit_cnt_reg + 4'd1;
                        emit = '{valid: 1'b1, kind: EV_STOLEN, slot: eidx_w[3:0],
                                 released_count: 5'd0, active_voices: act_dec_w[4:0],
                                 last: 1'b0};
                    end
                end
            end
            S_AVICT:
            begin
                if (out_free)
                begin
                    status_next[vict_reg] = ST_FREE;
                    active_next           = act_dec;
                    emit = '{valid: 1'b1, kind: EV_STOLEN, slot: vict_w[3:0],
                             released_count: 5'd0, active_voices: act_dec_w[4:0],
                             last: 1'b0};
                end
            end
            S_AWRITE:
            begin
                if (out_free)
                begin
                    mem_we                = 1'b1;
                    age_next              = age_inc;
                    status_next[vict_reg] = ST_HELD;
                    active_next           = act_inc;
                    emit = '{valid: 1'b1, kind: EV_ALLOC, slot: vict_w[3:0],
                             released_count: 5'd0, active_voices: act_inc_w[4:0],
                             last: 1'b1};
                end
            end
            S_RSCAN:
            begin
                if (eval_vld_reg && cmp_hit && cur_status == ST_HELD)
                begin
                    status_next[eval_idx_reg] = ST_RELEASING;
                    rel_cnt_next              = rel_cnt_reg + CW'(1);
                end
            end
            S_REMIT:
            begin
                if (out_free)
                begin
                    emit = '{valid: 1'b1, kind: EV_RELEASE, slot: 4'd0,
                             released_count: rel_w[4:0], active_voices: act_w[4:0],
                             last: 1'b1};
                end
            end
            S_CLEAR:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        status_next[i] = ST_FREE;
                    end
                    active_next = '0;
                    age_next    = '0;
                    emit = '{valid: 1'b1, kind: EV_CLEAR, slot: 4'd0,
                             released_count: 5'd0, active_voices: 5'd0,
                             last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            age_reg      <= '0;
            eval_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                status_reg[i] <= ST_FREE;
            end
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            age_reg      <= age_next;
            eval_vld_reg <= eval_vld_next;
            cnt_reg      <= cnt_next;
            status_reg   <= status_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        eval_idx_reg   <= eval_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        rel_found_reg  <= rel_found_next;
        rel_idx_reg    <= rel_idx_next;
        rel_best_reg   <= rel_best_next;
        held_found_reg <= held_found_next;
        held_idx_reg   <= held_idx_next;
        held_best_reg  <= held_best_next;
        vict_reg       <= vict_next;
        vg_reg         <= vg_next;
        emit_cnt_reg   <= emit_cnt_next;
        rel_cnt_reg    <= rel_cnt_next;
    end

endmodule

// ===== design/voice_allocator_with_stealing.sv =====
// ----------------------------------------------------------------------------
// voice_allocator_with_stealing
// polyphonic voice allocator with oldest-first stealing and note groups
// ----------------------------------------------------------------------------
// The pool holds VOICES slots; each slot is free, held or releasing and keeps
// channel, note, velocity, note group and an age stamp in a small record
// memory. One item is worked on at a time and in_stall stays high until the
// last result item of that item has been loaded into the output register.
// Allocate and release walk the record memory one slot per cycle through a
// single shared compare unit; the note-group sweep pauses while a stolen
// item waits for the output register. An allocate with no free slot steals:
// it adds a victim item, and a note-group sweep when the victim has a
// nonzero group. An output stall holds the sequencer while it has a result
// to load.
// Results: a steal gives one stolen item per freed group member (the first
// fifteen only are reported), then the victim, then the allocation; release
// and clear give one item each; opcode 3 gives none. The last field marks the
// final result of each item.
// ----------------------------------------------------------------------------
module voice_allocator_with_stealing
    import vas_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [3:0]  channel,
    input  logic [6:0]  note,
    input  logic [6:0]  velocity,
    input  logic [15:0] group_id,

    // event channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [3:0]  slot,
    output logic [4:0]  released_count,
    output logic [4:0]  active_voices,
    output logic        last
);

    logic   ctrl_idle;
    logic   accept;
    logic   out_free;
    cmd_t   cmd;
    emit_t  emit;

    // output register state
    logic        out_valid_reg;
    event_t      kind_reg;
    logic [3:0]  slot_reg;
    logic [4:0]  rel_reg;
    logic [4:0]  active_reg;
    logic        last_reg;

    // new items only while the sequencer sits idle
    assign in_stall = !ctrl_idle;
    assign accept   = in_valid && ctrl_idle;

    // the output register takes a new result when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    assign cmd = '{opcode:   opcode,
                   channel:  channel,
                   note:     note,
                   velocity: velocity,
                   group_id: group_id};

    vas_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cmd_in   (cmd),
        .out_free (out_free),
        .idle     (ctrl_idle),
        .emit     (emit)
    );

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, loaded only with a fresh result
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            kind_reg   <= emit.kind;
            slot_reg   <= emit.slot;
            rel_reg    <= emit.released_count;
            active_reg <= emit.active_voices;
            last_reg   <= emit.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = kind_reg;
    assign slot           = slot_reg;
    assign released_count = rel_reg;
    assign active_voices  = active_reg;
    assign last           = last_reg;

endmodule
